[rtl/stm_pkg.sv]
package stm_pkg;

	// Default build of the filter
	localparam int WINDOW_DEF      = 31;
	localparam int TRIM_DEF        = 5;
	localparam int SAMPLE_BITS_DEF = 12;

	// Field widths
	localparam int SAMPLE_W = 12;
	localparam int MEAN_W   = 12;
	localparam int RAW_W    = 12;
	localparam int HEIGHT_W = 16;

	// Configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_ZERO_RAW    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FULL_RAW    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FULL_HEIGHT = 2'd2;

	localparam logic [RAW_W-1:0]    ZERO_RAW_RST    = 12'd520;
	localparam logic [RAW_W-1:0]    FULL_RAW_RST    = 12'd4095;
	localparam logic [HEIGHT_W-1:0] FULL_HEIGHT_RST = 16'd2000;

	// Shared divider: numerator covers a raw span times the height
	localparam int DIV_NUM_W = RAW_W + HEIGHT_W;
	localparam int DIV_DEN_W = RAW_W;
	localparam int DIV_STEPS = DIV_NUM_W / 2;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	typedef struct packed {
		logic load;      // take the input word, open the hole
		logic move;      // one bubble step, or drop the new entry in
		logic sum_clr;   // clear accumulator, point at first kept entry
		logic sum_acc;   // add one kept entry
		logic div_start; // launch the divider
		logic div_lvl;   // divider operands: level map instead of mean
		logic out_load;  // write the result word
	} cmd_t;

	typedef struct packed {
		logic move_done;
		logic sum_last;
		logic div_done;
		logic out_free;
	} sts_t;

endpackage

[rtl/stm_div.sv]
module stm_div (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [stm_pkg::DIV_NUM_W-1:0]   num,
	input  logic [stm_pkg::DIV_DEN_W-1:0]   den,
	output logic [stm_pkg::DIV_NUM_W-1:0]   quot,
	output logic                            done
);

	localparam int NW = stm_pkg::DIV_NUM_W;
	localparam int DW = stm_pkg::DIV_DEN_W;

	logic [DW-1:0]                  rem_q;
	logic [DW-1:0]                  den_q;
	logic [NW-1:0]                  quo_q;
	logic [stm_pkg::DIV_CNT_W-1:0]  cnt_q;
	logic                           busy_q;
	logic                           done_q;

	logic [DW:0]   r1;
	logic [DW:0]   r1_sub;
	logic [DW-1:0] r1_n;
	logic          b1;
	logic [DW:0]   r2;
	logic [DW:0]   r2_sub;
	logic [DW-1:0] r2_n;
	logic          b2;

	// Two restoring steps per cycle
	always_comb begin
		r1     = {rem_q, quo_q[NW-1]};
		b1     = (r1 >= {1'b0, den_q});
		r1_sub = r1 - {1'b0, den_q};
		r1_n   = b1 ? r1_sub[DW-1:0] : r1[DW-1:0];
		r2     = {r1_n, quo_q[NW-2]};
		b2     = (r2 >= {1'b0, den_q});
		r2_sub = r2 - {1'b0, den_q};
		r2_n   = b2 ? r2_sub[DW-1:0] : r2[DW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == stm_pkg::DIV_CNT_W'(stm_pkg::DIV_STEPS - 1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == stm_pkg::DIV_CNT_W'(stm_pkg::DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			den_q <= den;
			quo_q <= num;
		end else if (busy_q) begin
			rem_q <= r2_n;
			quo_q <= {quo_q[NW-3:0], b1, b2};
		end
	end

	assign quot = quo_q;
	assign done = done_q;

endmodule

[rtl/stm_dp.sv]
module stm_dp #(
	parameter int WINDOW      = stm_pkg::WINDOW_DEF,
	parameter int TRIM        = stm_pkg::TRIM_DEF,
	parameter int SAMPLE_BITS = stm_pkg::SAMPLE_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  stm_pkg::cmd_t                     cmd,
	output stm_pkg::sts_t                     sts,
	input  logic [stm_pkg::SAMPLE_W-1:0]      sample,
	input  logic                              cfg_valid,
	input  logic [stm_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [stm_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                              out_ready,
	output logic                              out_valid,
	output logic [stm_pkg::MEAN_W-1:0]        trimmed_mean,
	output logic [stm_pkg::HEIGHT_W-1:0]      level_mm
);

	localparam int W        = WINDOW;
	localparam int IW       = $clog2(W);
	localparam int EFF_TRIM = (2 * TRIM >= W) ? ((W - 1) / 2) : TRIM;
	localparam int KEPT     = W - 2 * EFF_TRIM;
	localparam int VAL_W    = (SAMPLE_BITS < stm_pkg::SAMPLE_W) ? SAMPLE_BITS
	                                                            : stm_pkg::SAMPLE_W;
	localparam int SUM_W    = VAL_W + $clog2(KEPT + 1);

	// Sorted window cells
	logic [VAL_W-1:0] val_q [W];
	logic [IW-1:0]    age_q [W];
	logic [W-1:0]     hole_q;
	logic [VAL_W-1:0] mv_q;
	logic [IW-1:0]    mage_q;
	logic [IW-1:0]    next_age_q;

	logic [W-1:0] match;
	logic [W-1:0] go_l;
	logic [W-1:0] go_r;
	logic         go_left;
	logic         go_right;

	// Accumulator and level path
	logic [SUM_W-1:0]              sum_q;
	logic [IW-1:0]                 sum_idx_q;
	logic [stm_pkg::MEAN_W-1:0]    mean_q;
	logic [stm_pkg::DIV_NUM_W-1:0] prod_q;
	logic [stm_pkg::RAW_W-1:0]     zero_q;
	logic [stm_pkg::RAW_W-1:0]     full_q;
	logic [stm_pkg::HEIGHT_W-1:0]  height_q;
	logic [stm_pkg::MEAN_W-1:0]    trimmed_mean_q;
	logic [stm_pkg::HEIGHT_W-1:0]  level_mm_q;
	logic                          out_valid_q;

	logic [stm_pkg::DIV_NUM_W-1:0] div_num;
	logic [stm_pkg::DIV_DEN_W-1:0] div_den;
	logic [stm_pkg::DIV_NUM_W-1:0] div_quot;
	logic                          div_done;
	logic [stm_pkg::RAW_W-1:0]     span;
	logic [stm_pkg::RAW_W-1:0]     rise;
	logic [stm_pkg::HEIGHT_W-1:0]  level_sel;

	for (genvar g = 0; g < W; g++) begin : g_cell
		assign match[g] = (age_q[g] == next_age_q);
		if (g > 0) begin : g_l
			assign go_l[g] = hole_q[g] && (mv_q < val_q[g-1]);
		end else begin : g_l0
			assign go_l[g] = 1'b0;
		end
		if (g < W - 1) begin : g_r
			assign go_r[g] = hole_q[g] && (mv_q > val_q[g+1]);
		end else begin : g_rn
			assign go_r[g] = 1'b0;
		end
	end

	assign go_left  = |go_l;
	assign go_right = |go_r;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < W; i++) begin
				val_q[i] <= '0;
				age_q[i] <= IW'(i);
			end
			next_age_q <= '0;
		end else if (cmd.load) begin
			next_age_q <= (next_age_q == IW'(W - 1)) ? '0 : next_age_q + 1'b1;
		end else if (cmd.move) begin
			if (go_left) begin
				for (int i = 1; i < W; i++) begin
					if (hole_q[i]) begin
						val_q[i] <= val_q[i-1];
						age_q[i] <= age_q[i-1];
					end
				end
			end else if (go_right) begin
				for (int i = 0; i < W - 1; i++) begin
					if (hole_q[i]) begin
						val_q[i] <= val_q[i+1];
						age_q[i] <= age_q[i+1];
					end
				end
			end else begin
				for (int i = 0; i < W; i++) begin
					if (hole_q[i]) begin
						val_q[i] <= mv_q;
						age_q[i] <= mage_q;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			// Missing tag falls back to the first entry
			hole_q <= (|match) ? match : W'(1);
			mv_q   <= sample[VAL_W-1:0];
			mage_q <= next_age_q;
		end else if (cmd.move) begin
			if (go_left) begin
				hole_q <= {1'b0, hole_q[W-1:1]};
			end else if (go_right) begin
				hole_q <= {hole_q[W-2:0], 1'b0};
			end
		end
	end

	assign rise = mean_q - zero_q;

	always_ff @(posedge clk) begin
		if (cmd.sum_clr) begin
			sum_q     <= '0;
			sum_idx_q <= IW'(EFF_TRIM);
		end else if (cmd.sum_acc) begin
			sum_q     <= sum_q + SUM_W'(val_q[sum_idx_q]);
			sum_idx_q <= sum_idx_q + 1'b1;
		end
		// Product settles while the level operands are selected, ahead of the start
		if (cmd.div_lvl && !cmd.div_start) begin
			prod_q <= stm_pkg::DIV_NUM_W'(rise) * stm_pkg::DIV_NUM_W'(height_q);
		end
		if (div_done && !cmd.div_lvl) begin
			mean_q <= div_quot[stm_pkg::MEAN_W-1:0];
		end
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zero_q   <= stm_pkg::ZERO_RAW_RST;
			full_q   <= stm_pkg::FULL_RAW_RST;
			height_q <= stm_pkg::FULL_HEIGHT_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				stm_pkg::REG_ZERO_RAW:    zero_q   <= cfg_data[stm_pkg::RAW_W-1:0];
				stm_pkg::REG_FULL_RAW:    full_q   <= cfg_data[stm_pkg::RAW_W-1:0];
				stm_pkg::REG_FULL_HEIGHT: height_q <= cfg_data[stm_pkg::HEIGHT_W-1:0];
				default: ;
			endcase
		end
	end

	assign span    = full_q - zero_q;
	assign div_num = cmd.div_lvl ? prod_q : stm_pkg::DIV_NUM_W'(sum_q);
	assign div_den = cmd.div_lvl ? span : stm_pkg::DIV_DEN_W'(KEPT);

	stm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (div_num),
		.den    (div_den),
		.quot   (div_quot),
		.done   (div_done)
	);

	always_comb begin
		if (full_q <= zero_q || mean_q <= zero_q) begin
			level_sel = '0;
		end else if (mean_q >= full_q) begin
			level_sel = height_q;
		end else begin
			level_sel = div_quot[stm_pkg::HEIGHT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			trimmed_mean_q <= mean_q;
			level_mm_q     <= level_sel;
		end
	end

	assign sts.move_done = !go_left && !go_right;
	assign sts.sum_last  = (sum_idx_q == IW'(W - EFF_TRIM - 1));
	assign sts.div_done  = div_done;
	assign sts.out_free  = !out_valid_q || out_ready;

	assign out_valid    = out_valid_q;
	assign trimmed_mean = trimmed_mean_q;
	assign level_mm     = level_mm_q;

endmodule

[rtl/stm_ctrl.sv]
module stm_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  stm_pkg::sts_t sts,
	output stm_pkg::cmd_t cmd
);

	localparam logic [3:0] ST_IDLE   = 4'd0;
	localparam logic [3:0] ST_MOVE   = 4'd1;
	localparam logic [3:0] ST_SUM    = 4'd2;
	localparam logic [3:0] ST_DIVM   = 4'd3;
	localparam logic [3:0] ST_DIVM_W = 4'd4;
	localparam logic [3:0] ST_DIVL   = 4'd5;
	localparam logic [3:0] ST_DIVL_W = 4'd6;
	localparam logic [3:0] ST_OUT    = 4'd7;
	localparam logic [3:0] ST_MUL    = 4'd8;

	logic [3:0] state_q;
	logic [3:0] state_d;

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_MOVE;
				end
			end
			ST_MOVE: begin
				cmd.move = 1'b1;
				if (sts.move_done) begin
					cmd.sum_clr = 1'b1;
					state_d     = ST_SUM;
				end
			end
			ST_SUM: begin
				cmd.sum_acc = 1'b1;
				if (sts.sum_last) begin
					state_d = ST_DIVM;
				end
			end
			ST_DIVM: begin
				cmd.div_start = 1'b1;
				state_d       = ST_DIVM_W;
			end
			ST_DIVM_W: begin
				if (sts.div_done) begin
					state_d = ST_MUL;
				end
			end
			ST_MUL: begin
				// Product is captured here, divider starts next cycle
				cmd.div_lvl = 1'b1;
				state_d     = ST_DIVL;
			end
			ST_DIVL: begin
				cmd.div_lvl   = 1'b1;
				cmd.div_start = 1'b1;
				state_d       = ST_DIVL_W;
			end
			ST_DIVL_W: begin
				cmd.div_lvl = 1'b1;
				if (sts.div_done) begin
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				cmd.div_lvl = 1'b1;
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

[rtl/sliding_trimmed_mean_level.sv]
// One word is in flight at a time; its steps are the bubble, the kept sum and two passes
// of the two-bit-per-cycle divider. The next word is taken once the result sits in the
// output register, so it overlaps a result still waiting.
// Reset (arst_n low, asynchronous): window cleared to zeros tagged 0..WINDOW-1,
// age counter 0, calibration back to 520 / 4095 / 2000 mm, no result pending.
module sliding_trimmed_mean_level #(
	parameter int WINDOW      = stm_pkg::WINDOW_DEF,
	parameter int TRIM        = stm_pkg::TRIM_DEF,
	parameter int SAMPLE_BITS = stm_pkg::SAMPLE_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// sample channel
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [stm_pkg::SAMPLE_W-1:0]   sample,
	// result channel
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [stm_pkg::MEAN_W-1:0]     trimmed_mean,
	output logic [stm_pkg::HEIGHT_W-1:0]   level_mm,
	// calibration write channel
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [stm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [stm_pkg::CFG_DATA_W-1:0] cfg_data
);

	stm_pkg::cmd_t cmd;
	stm_pkg::sts_t sts;

	// Calibration writes land at once; an unknown index is dropped in the datapath
	assign cfg_ready = 1'b1;

	// Sequencer: load word, bubble into place, sum kept entries, divide twice, write
	stm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Window cells, accumulator, multiplier, shared divider and output register
	stm_dp #(
		.WINDOW      (WINDOW),
		.TRIM        (TRIM),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.sample       (sample),
		.cfg_valid    (cfg_valid),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.out_ready    (out_ready),
		.out_valid    (out_valid),
		.trimmed_mean (trimmed_mean),
		.level_mm     (level_mm)
	);

endmodule
